// ===== sv/buddy_block_allocator_macros.svh =====
// assertion helpers used by the checker file
`ifndef BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_MACROS_SVH

// same-cycle implication, held off during reset
`define BBA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bba assertion failed");

// next-cycle implication, held off during reset
`define BBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bba assertion failed");

`endif

// ===== sv/bba_pkg.sv =====
`timescale 1ns / 1ps
package bba_pkg;

    localparam int LEAF_COUNT = 1024;
    localparam int MAX_ORDER  = 20;
    localparam int NODE_SLOTS = 2 * LEAF_COUNT;
    localparam int NODE_W     = $clog2(NODE_SLOTS);
    localparam int LEAF_LOG   = $clog2(LEAF_COUNT);
    localparam int LVL_W      = $clog2(LEAF_LOG + 1);
    localparam int MAX_SPAN   = (LEAF_LOG < 10) ? LEAF_LOG : 10;

    localparam int CMD_W  = 1;
    localparam int REQ_W  = 21;
    localparam int OFF_W  = 20;
    localparam int ORD_W  = 5;
    localparam int STS_W  = 2;
    localparam int TOT_W  = 22;
    localparam int MIN_W  = 4;
    localparam int HDR_W  = 7;
    localparam int CFG_W  = 7;
    localparam int CIDX_W = 2;
    localparam int ST_W   = 2;

    localparam logic [MIN_W-1:0] MIN_LO = MIN_W'(3);
    localparam logic [MIN_W-1:0] MIN_HI = MIN_W'(10);

    // node codes
    localparam logic [ST_W-1:0] ST_UNUSED = 2'd0;
    localparam logic [ST_W-1:0] ST_FREE   = 2'd1;
    localparam logic [ST_W-1:0] ST_SPLIT  = 2'd2;
    localparam logic [ST_W-1:0] ST_ALLOC  = 2'd3;

    // commands
    localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

    // result status
    localparam logic [STS_W-1:0] STS_OK      = 2'd0;
    localparam logic [STS_W-1:0] STS_NOFIT   = 2'd1;
    localparam logic [STS_W-1:0] STS_BADFREE = 2'd2;
    localparam logic [STS_W-1:0] STS_RSVD    = 2'd3;

    // register indexes
    localparam logic [CIDX_W-1:0] REG_POOL_ORDER   = 2'd0;
    localparam logic [CIDX_W-1:0] REG_MIN_ORDER    = 2'd1;
    localparam logic [CIDX_W-1:0] REG_HEADER_BYTES = 2'd2;

    typedef logic [NODE_W-1:0] node_idx_t;

endpackage

// ===== sv/bba_req_if.sv =====
`timescale 1ns / 1ps
interface bba_req_if
    import bba_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [REQ_W-1:0] request_bytes;
    logic [OFF_W-1:0] block_offset;

    modport source (output valid, output command, output request_bytes,
                    output block_offset, input ready);
    modport sink   (input valid, input command, input request_bytes,
                    input block_offset, output ready);
endinterface

// ===== sv/bba_rsp_if.sv =====
`timescale 1ns / 1ps
interface bba_rsp_if
    import bba_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [STS_W-1:0] status;
    logic [OFF_W-1:0] granted_offset;
    logic [ORD_W-1:0] granted_order;
    logic [TOT_W-1:0] allocated_total;

    modport source (output valid, output status, output granted_offset,
                    output granted_order, output allocated_total, input ready);
    modport sink   (input valid, input status, input granted_offset,
                    input granted_order, input allocated_total, output ready);
endinterface

// ===== sv/bba_ram.sv =====
`timescale 1ns / 1ps
module bba_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== sv/buddy_block_allocator.sv =====
// allocate: decode the order, scan the tree level by level for a free node, then split it down to the target order
// free: walk down from the root to the allocated node, then merge it with free buddies on the way back up
// one request at a time; no new request is taken until the response is registered
// reset: async active low; a clearing pass then runs over all 2048 node ram entries
// a write to a listed configuration register restarts the same clearing pass
`timescale 1ns / 1ps
module buddy_block_allocator
    import bba_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    bba_req_if.sink           req,
    bba_rsp_if.source         rsp
);

    // controller states
    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_ADEC    = 4'd2;
    localparam logic [3:0] S_SCAN    = 4'd3;
    localparam logic [3:0] S_SPLIT_A = 4'd4;
    localparam logic [3:0] S_SPLIT_B = 4'd5;
    localparam logic [3:0] S_AFIN    = 4'd6;
    localparam logic [3:0] S_FWALK   = 4'd7;
    localparam logic [3:0] S_FCHK    = 4'd8;
    localparam logic [3:0] S_MRD     = 4'd9;
    localparam logic [3:0] S_MCHK    = 4'd10;
    localparam logic [3:0] S_MW2     = 4'd11;
    localparam logic [3:0] S_RESP    = 4'd12;

    localparam node_idx_t LAST_NODE = node_idx_t'(NODE_SLOTS - 1);

    logic [3:0]       state_reg, state_next;
    node_idx_t        clr_reg, clr_next;
    logic [ORD_W-1:0] pool_order_reg;
    logic [MIN_W-1:0] min_order_reg;
    logic [HDR_W-1:0] header_reg;
    logic [TOT_W-1:0] bytes_reg, bytes_next;

    // request capture
    logic [REQ_W-1:0] rbytes_reg, rbytes_next;
    logic [OFF_W-1:0] off_reg, off_next;
    logic [ORD_W-1:0] order_reg, order_next;
    logic [LVL_W-1:0] target_reg, target_next;

    // tree walk
    node_idx_t        idx_reg, idx_next;
    logic [LVL_W-1:0] depth_reg, depth_next;

    // level scan, one read issued per cycle, data checked in the cycle after
    node_idx_t        scan_reg, scan_next;
    logic [LVL_W-1:0] slvl_reg, slvl_next;
    logic             sdone_reg, sdone_next;
    logic             pend_reg, pend_next;
    node_idx_t        pidx_reg, pidx_next;
    logic [LVL_W-1:0] plvl_reg, plvl_next;

    // pending result
    logic [STS_W-1:0] res_sts_reg, res_sts_next;
    logic [OFF_W-1:0] res_off_reg, res_off_next;
    logic [ORD_W-1:0] res_ord_reg, res_ord_next;

    // output register
    logic             ovalid_reg, ovalid_next;
    logic [STS_W-1:0] osts_reg, osts_next;
    logic [OFF_W-1:0] ooff_reg, ooff_next;
    logic [ORD_W-1:0] oord_reg, oord_next;
    logic [TOT_W-1:0] otot_reg, otot_next;

    // node ram port
    logic             mem_we;
    node_idx_t        mem_waddr, mem_raddr;
    logic [ST_W-1:0]  mem_wdata, mem_rdata;

    // effective geometry
    logic [MIN_W-1:0] geo_m;
    logic [ORD_W-1:0] geo_p, p_lo, p_span;
    logic [LVL_W-1:0] levels;

    // helpers
    logic [TOT_W-1:0] need, need_m1;
    logic [ORD_W-1:0] ceil_ord, fit_ord;
    logic [ORD_W-1:0] walk_sh;
    logic [OFF_W-1:0] low_mask;
    logic             child_bit;
    node_idx_t        child_idx, sib_idx, parent_idx, lvl_end, lvl_up, apos;
    logic [TOT_W-1:0] charge;

    bba_ram #(.WIDTH(ST_W), .DEPTH(NODE_SLOTS)) u_nodes (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // clamp min order to 3..10, pool order to min..min+span and the order limit
    always_comb
    begin
        geo_m = min_order_reg;
        if (geo_m < MIN_LO)
        begin
            geo_m = MIN_LO;
        end
        if (geo_m > MIN_HI)
        begin
            geo_m = MIN_HI;
        end
        p_lo   = (pool_order_reg < ORD_W'(geo_m)) ? ORD_W'(geo_m) : pool_order_reg;
        p_span = ORD_W'(geo_m) + ORD_W'(MAX_SPAN);
        geo_p  = (p_lo > p_span) ? p_span : p_lo;
        if (geo_p > ORD_W'(MAX_ORDER))
        begin
            geo_p = ORD_W'(MAX_ORDER);
        end
        levels = LVL_W'(geo_p - ORD_W'(geo_m));
    end

    // round request plus header up to a power of two, no smaller than the min order
    always_comb
    begin
        need     = TOT_W'(rbytes_reg) + TOT_W'(header_reg);
        need_m1  = need - TOT_W'(1);
        ceil_ord = '0;
        if (need > TOT_W'(1))
        begin
            for (int i = 0; i < TOT_W; i++)
            begin
                if (need_m1[i])
                begin
                    ceil_ord = ORD_W'(i + 1);
                end
            end
        end
        fit_ord = (ceil_ord < ORD_W'(geo_m)) ? ORD_W'(geo_m) : ceil_ord;
    end

    // tree arithmetic
    always_comb
    begin
        walk_sh    = geo_p - ORD_W'(depth_reg);
        low_mask   = (OFF_W'(1) << walk_sh) - OFF_W'(1);
        child_bit  = off_reg[walk_sh - ORD_W'(1)];
        child_idx  = (idx_reg << 1) + node_idx_t'(1) + node_idx_t'(child_bit);
        sib_idx    = idx_reg[0] ? idx_reg + node_idx_t'(1) : idx_reg - node_idx_t'(1);
        parent_idx = (idx_reg - node_idx_t'(1)) >> 1;
        lvl_end    = node_idx_t'((NODE_W'(1) << slvl_reg) - NODE_W'(1))
                   + node_idx_t'(NODE_W'(1) << slvl_reg) - node_idx_t'(1);
        lvl_up     = (node_idx_t'(1) << (slvl_reg - LVL_W'(1))) - node_idx_t'(1);
        apos       = idx_reg - ((node_idx_t'(1) << target_reg) - node_idx_t'(1));
        charge     = (TOT_W'(1) << walk_sh) + TOT_W'(header_reg);
    end

    // controller
    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        bytes_next   = bytes_reg;
        rbytes_next  = rbytes_reg;
        off_next     = off_reg;
        order_next   = order_reg;
        target_next  = target_reg;
        idx_next     = idx_reg;
        depth_next   = depth_reg;
        scan_next    = scan_reg;
        slvl_next    = slvl_reg;
        sdone_next   = sdone_reg;
        pend_next    = pend_reg;
        pidx_next    = pidx_reg;
        plvl_next    = plvl_reg;
        res_sts_next = res_sts_reg;
        res_off_next = res_off_reg;
        res_ord_next = res_ord_reg;
        ovalid_next  = ovalid_reg;
        osts_next    = osts_reg;
        ooff_next    = ooff_reg;
        oord_next    = oord_reg;
        otot_next    = otot_reg;
        mem_we       = 1'b0;
        mem_waddr    = idx_reg;
        mem_wdata    = ST_UNUSED;
        mem_raddr    = idx_reg;

        // output slot drains independently of the controller
        if (ovalid_reg && rsp.ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = (clr_reg == '0) ? ST_FREE : ST_UNUSED;
                clr_next  = clr_reg + node_idx_t'(1);
                if (clr_reg == LAST_NODE)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    rbytes_next  = req.request_bytes;
                    off_next     = req.block_offset;
                    idx_next     = '0;
                    depth_next   = '0;
                    res_sts_next = STS_OK;
                    res_off_next = '0;
                    res_ord_next = '0;
                    if (req.command == CMD_ALLOC)
                    begin
                        state_next = S_ADEC;
                    end
                    else if ((TOT_W'(req.block_offset) >> geo_p) != '0)
                    begin
                        res_sts_next = STS_BADFREE;
                        state_next   = S_RESP;
                    end
                    else
                    begin
                        state_next = S_FWALK;
                    end
                end
            end
            S_ADEC:
            begin
                order_next = fit_ord;
                if (fit_ord > geo_p)
                begin
                    res_sts_next = STS_NOFIT;
                    state_next   = S_RESP;
                end
                else
                begin
                    target_next = LVL_W'(geo_p - fit_ord);
                    scan_next   = (node_idx_t'(1) << LVL_W'(geo_p - fit_ord)) - node_idx_t'(1);
                    slvl_next   = LVL_W'(geo_p - fit_ord);
                    sdone_next  = 1'b0;
                    pend_next   = 1'b0;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN:
            begin
                mem_raddr = scan_reg;
                if (pend_reg && mem_rdata == ST_FREE)
                begin
                    idx_next   = pidx_reg;
                    depth_next = plvl_reg;
                    state_next = S_SPLIT_A;
                end
                else if (sdone_reg)
                begin
                    res_sts_next = STS_NOFIT;
                    state_next   = S_RESP;
                end
                else
                begin
                    pend_next = 1'b1;
                    pidx_next = scan_reg;
                    plvl_next = slvl_reg;
                    if (scan_reg == lvl_end)
                    begin
                        if (slvl_reg == '0)
                        begin
                            sdone_next = 1'b1;
                        end
                        else
                        begin
                            slvl_next = slvl_reg - LVL_W'(1);
                            scan_next = lvl_up;
                        end
                    end
                    else
                    begin
                        scan_next = scan_reg + node_idx_t'(1);
                    end
                end
            end
            S_SPLIT_A:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                if (depth_reg == target_reg)
                begin
                    mem_wdata  = ST_ALLOC;
                    state_next = S_AFIN;
                end
                else
                begin
                    mem_wdata  = ST_SPLIT;
                    state_next = S_SPLIT_B;
                end
            end
            S_SPLIT_B:
            begin
                // upper half stays free, walk on down the lower half
                mem_we     = 1'b1;
                mem_waddr  = (idx_reg << 1) + node_idx_t'(2);
                mem_wdata  = ST_FREE;
                idx_next   = (idx_reg << 1) + node_idx_t'(1);
                depth_next = depth_reg + LVL_W'(1);
                state_next = S_SPLIT_A;
            end
            S_AFIN:
            begin
                res_off_next = OFF_W'(apos) << order_reg;
                res_ord_next = order_reg;
                bytes_next   = bytes_reg + (TOT_W'(1) << order_reg) + TOT_W'(header_reg);
                state_next   = S_RESP;
            end
            S_FWALK:
            begin
                mem_raddr  = idx_reg;
                state_next = S_FCHK;
            end
            S_FCHK:
            begin
                if (mem_rdata == ST_ALLOC)
                begin
                    if ((off_reg & low_mask) != '0)
                    begin
                        res_sts_next = STS_BADFREE;
                        state_next   = S_RESP;
                    end
                    else
                    begin
                        res_off_next = off_reg;
                        res_ord_next = walk_sh;
                        bytes_next   = (bytes_reg >= charge) ? bytes_reg - charge : '0;
                        state_next   = S_MRD;
                    end
                end
                else if (mem_rdata == ST_SPLIT && depth_reg < levels)
                begin
                    // read the child now, its data is checked next cycle
                    mem_raddr  = child_idx;
                    idx_next   = child_idx;
                    depth_next = depth_reg + LVL_W'(1);
                end
                else
                begin
                    res_sts_next = STS_BADFREE;
                    state_next   = S_RESP;
                end
            end
            S_MRD:
            begin
                if (idx_reg == '0)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = idx_reg;
                    mem_wdata  = ST_FREE;
                    state_next = S_RESP;
                end
                else
                begin
                    mem_raddr  = sib_idx;
                    state_next = S_MCHK;
                end
            end
            S_MCHK:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                if (mem_rdata != ST_FREE)
                begin
                    mem_wdata  = ST_FREE;
                    state_next = S_RESP;
                end
                else
                begin
                    mem_wdata  = ST_UNUSED;
                    state_next = S_MW2;
                end
            end
            S_MW2:
            begin
                mem_we     = 1'b1;
                mem_waddr  = sib_idx;
                mem_wdata  = ST_UNUSED;
                idx_next   = parent_idx;
                state_next = S_MRD;
            end
            S_RESP:
            begin
                if (!ovalid_reg || rsp.ready)
                begin
                    ovalid_next = 1'b1;
                    osts_next   = res_sts_reg;
                    ooff_next   = res_off_reg;
                    oord_next   = res_ord_reg;
                    otot_next   = bytes_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // a write to a listed register clears the pool, other indexes do nothing
        if (cfg_we && cfg_index <= REG_HEADER_BYTES)
        begin
            state_next = S_CLEAR;
            clr_next   = '0;
            bytes_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            pool_order_reg <= ORD_W'(15);
            min_order_reg  <= MIN_W'(5);
            header_reg     <= HDR_W'(24);
            bytes_reg      <= '0;
            ovalid_reg     <= 1'b0;
            sdone_reg      <= 1'b0;
            pend_reg       <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            bytes_reg  <= bytes_next;
            ovalid_reg <= ovalid_next;
            sdone_reg  <= sdone_next;
            pend_reg   <= pend_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_POOL_ORDER:   pool_order_reg <= cfg_data[ORD_W-1:0];
                    REG_MIN_ORDER:    min_order_reg  <= cfg_data[MIN_W-1:0];
                    REG_HEADER_BYTES: header_reg     <= cfg_data[HDR_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rbytes_reg  <= rbytes_next;
        off_reg     <= off_next;
        order_reg   <= order_next;
        target_reg  <= target_next;
        idx_reg     <= idx_next;
        depth_reg   <= depth_next;
        scan_reg    <= scan_next;
        slvl_reg    <= slvl_next;
        pidx_reg    <= pidx_next;
        plvl_reg    <= plvl_next;
        res_sts_reg <= res_sts_next;
        res_off_reg <= res_off_next;
        res_ord_reg <= res_ord_next;
        osts_reg    <= osts_next;
        ooff_reg    <= ooff_next;
        oord_reg    <= oord_next;
        otot_reg    <= otot_next;
    end

    assign req.ready           = (state_reg == S_IDLE) && !cfg_we;
    assign rsp.valid           = ovalid_reg;
    assign rsp.status          = osts_reg;
    assign rsp.granted_offset  = ooff_reg;
    assign rsp.granted_order   = oord_reg;
    assign rsp.allocated_total = otot_reg;

endmodule

// ===== sv/bba_checker.sv =====
`timescale 1ns / 1ps
`include "buddy_block_allocator_macros.svh"
module bba_checker
    import bba_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input logic [STS_W-1:0] rsp_status,
    input logic [OFF_W-1:0] rsp_offset,
    input logic [ORD_W-1:0] rsp_order
);
    // one request at a time: taking one closes the input
    `BBA_ASSERT_NEXT(a_busy_after_take, clk, rst_n, req_valid && req_ready, !req_ready)
    `BBA_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)
    `BBA_ASSERT_NEXT(a_rsp_stable, clk, rst_n, rsp_valid && !rsp_ready, $stable(rsp_status))
    `BBA_ASSERT_NOW(a_no_rsvd, clk, rst_n, rsp_valid, rsp_status != STS_RSVD)
    `BBA_ASSERT_NOW(a_err_zero, clk, rst_n, rsp_valid && rsp_status != STS_OK,
        rsp_offset == '0 && rsp_order == '0)
endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_offset (rsp.granted_offset),
    .rsp_order  (rsp.granted_order)
);
